### hdl/sacl_pkg.sv
// Shared widths, register indexes and controller/datapath interface types.
package sacl_pkg;

   localparam int OFS_W   = 4;
   localparam int SETB_W  = 4;
   localparam int WAYB_W  = 2;
   localparam int SET_W   = 2**SETB_W - 1;
   localparam int WFULL_W = 2**WAYB_W;
   localparam int BASE_W  = SET_W + 2**WAYB_W - 1;
   localparam int CNT_W   = 32;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
   localparam logic [1:0] REG_SET_BITS    = 2'd1;
   localparam logic [1:0] REG_WAY_BITS    = 2'd2;

   localparam logic [OFS_W-1:0]  OFS_RST  = 4'd4;
   localparam logic [SETB_W-1:0] SETB_RST = 4'd8;
   localparam logic [WAYB_W-1:0] WAYB_RST = 2'd0;

   typedef struct packed {
      logic clear;
      logic load;
      logic mod_step;
      logic scan_start;
      logic scan;
      logic write;
   } sacl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic mod_done;
      logic scan_done;
      logic out_free;
   } sacl_sts_type;

endpackage

### hdl/sacl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/sacl_ctrl.sv
// Sequencer: clearing pass, set index reduction, way scan and write-back.
module sacl_ctrl
   import sacl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  sacl_sts_type st,
   output sacl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_SCAN,
      ST_WRITE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (st.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (st.mod_done) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (st.scan_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // hold until the result register can take the new result
            if (st.out_free) begin
               cmd.write = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

### hdl/sacl_dp.sv
// Datapath: address split, line index reduction, way scan, tag/stamp stores, counters.
module sacl_dp
   import sacl_pkg::*;
#(
   parameter int LINES     = 256,
   parameter int MAX_WAYS  = 8,
   parameter int ADDR_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [OFS_W-1:0]  cfg_ofs,
   input  logic [SETB_W-1:0] cfg_setb,
   input  logic [WAYB_W-1:0] cfg_wayb,
   input  logic [31:0]       req_tdata,
   input  sacl_cmd_type      cmd,
   output sacl_sts_type      st,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [63:0]       rsp_tdata,
   output logic              rsp_tuser
);

   localparam int  LINE_W  = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int  WN_W    = $clog2(MAX_WAYS + 1);
   localparam int  MC_W    = 2;
   localparam bit  POW2    = ((LINES & (LINES - 1)) == 0);
   localparam int  TAG_DW  = ADDR_BITS + 1;
   localparam int  RS      = BASE_W + LINE_W;
   localparam int  RECIP_W = BASE_W + 2;
   localparam int  PROD_W  = BASE_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RS) + 64'(LINES) - 64'd1) / 64'(LINES));

   // request split
   logic [ADDR_BITS-1:0] addr;
   logic [OFS_W:0]       tag_sh;
   logic [SET_W:0]       set_one;
   logic [SET_W-1:0]     set_val;
   logic [WFULL_W-1:0]   ways_full;

   logic [ADDR_BITS-1:0] tag_ff, tag_in;
   logic [BASE_W-1:0]    base_ff, base_in;
   logic [WN_W-1:0]      ways_ff, ways_in;

   // line index reduction
   logic [BASE_W-1:0]    quo_ff, quo_in;
   logic [LINE_W-1:0]    rem_ff, rem_in;
   logic [MC_W-1:0]      mcnt_ff, mcnt_in;
   logic [PROD_W-1:0]    prod;
   logic [BASE_W-1:0]    rem_full;
   logic [LINE_W-1:0]    line0;

   // scan
   logic [LINE_W-1:0]    iss_line_ff, iss_line_in;
   logic [WN_W-1:0]      iss_k_ff, iss_k_in;
   logic                 rv_ff, rv_in;
   logic [LINE_W-1:0]    rv_line_ff, rv_line_in;
   logic                 hit_found_ff, hit_found_in;
   logic [LINE_W-1:0]    hit_line_ff, hit_line_in;
   logic                 inv_found_ff, inv_found_in;
   logic [LINE_W-1:0]    inv_line_ff, inv_line_in;
   logic                 vic_any_ff, vic_any_in;
   logic [LINE_W-1:0]    vic_line_ff, vic_line_in;
   logic [CNT_W-1:0]     vic_stamp_ff, vic_stamp_in;

   // clearing pass
   logic [LINE_W-1:0]    clr_idx_ff, clr_idx_in;

   // counters and result register
   logic [CNT_W-1:0]     acc_ff, acc_in;
   logic [CNT_W-1:0]     miss_ff, miss_in;
   logic [CNT_W-1:0]     acc_next, miss_next;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [CNT_W-1:0]     rsp_acc_ff, rsp_acc_in;
   logic [CNT_W-1:0]     rsp_miss_ff, rsp_miss_in;

   // stores
   logic                 tag_we;
   logic [LINE_W-1:0]    tag_waddr;
   logic [TAG_DW-1:0]    tag_wdata;
   logic [TAG_DW-1:0]    tag_rdata;
   logic [CNT_W-1:0]     stamp_rdata;
   logic [LINE_W-1:0]    wline;
   logic                 rd_valid;
   logic [ADDR_BITS-1:0] rd_tag;

   // ---------------- address split at accept
   always_comb begin
      addr      = req_tdata[ADDR_BITS-1:0];
      tag_sh    = (OFS_W+1)'(cfg_ofs) + (OFS_W+1)'(cfg_setb);
      set_one   = (SET_W+1)'(1) << cfg_setb;
      set_val   = SET_W'(addr >> cfg_ofs) & SET_W'(set_one - (SET_W+1)'(1));
      ways_full = WFULL_W'(1) << cfg_wayb;

      tag_in  = tag_ff;
      base_in = base_ff;
      ways_in = ways_ff;
      if (cmd.load) begin
         tag_in  = addr >> tag_sh;
         base_in = BASE_W'(set_val) << cfg_wayb;
         ways_in = (int'(ways_full) > MAX_WAYS) ? WN_W'(MAX_WAYS) : WN_W'(ways_full);
      end
   end

   // ---------------- base mod LINES: reciprocal multiply for the quotient, then the remainder
   always_comb begin
      prod     = PROD_W'(base_ff) * PROD_W'(RECIP);
      rem_full = base_ff - quo_ff * BASE_W'(LINES);
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      mcnt_in  = mcnt_ff;
      if (cmd.load) begin
         mcnt_in = MC_W'(2);
      end else if (cmd.mod_step && (mcnt_ff != '0)) begin
         mcnt_in = mcnt_ff - MC_W'(1);
         if (mcnt_ff == MC_W'(2)) begin
            quo_in = BASE_W'(prod >> RS);
         end else begin
            rem_in = LINE_W'(rem_full);
         end
      end
      line0 = POW2 ? LINE_W'(base_ff & BASE_W'(LINES - 1)) : rem_ff;
   end

   // ---------------- way scan, one read a cycle
   always_comb begin
      rd_valid = tag_rdata[ADDR_BITS];
      rd_tag   = tag_rdata[ADDR_BITS-1:0];

      iss_line_in  = iss_line_ff;
      iss_k_in     = iss_k_ff;
      rv_in        = 1'b0;
      rv_line_in   = iss_line_ff;
      hit_found_in = hit_found_ff;
      hit_line_in  = hit_line_ff;
      inv_found_in = inv_found_ff;
      inv_line_in  = inv_line_ff;
      vic_any_in   = vic_any_ff;
      vic_line_in  = vic_line_ff;
      vic_stamp_in = vic_stamp_ff;

      if (cmd.scan_start) begin
         iss_line_in  = line0;
         iss_k_in     = '0;
         hit_found_in = 1'b0;
         inv_found_in = 1'b0;
         vic_any_in   = 1'b0;
      end else begin
         if (cmd.scan && (iss_k_ff != ways_ff)) begin
            rv_in    = 1'b1;
            iss_k_in = iss_k_ff + WN_W'(1);
            if (iss_line_ff == LINE_W'(LINES - 1)) begin
               iss_line_in = '0;
            end else begin
               iss_line_in = iss_line_ff + LINE_W'(1);
            end
         end
         if (rv_ff) begin
            // first matching way wins, first empty way wins, lowest way on equal stamps
            if (!hit_found_ff && rd_valid && (rd_tag == tag_ff)) begin
               hit_found_in = 1'b1;
               hit_line_in  = rv_line_ff;
            end
            if (!inv_found_ff && !rd_valid) begin
               inv_found_in = 1'b1;
               inv_line_in  = rv_line_ff;
            end
            if (!vic_any_ff || (stamp_rdata < vic_stamp_ff)) begin
               vic_any_in   = 1'b1;
               vic_line_in  = rv_line_ff;
               vic_stamp_in = stamp_rdata;
            end
         end
      end
   end

   // ---------------- write-back, counters, result
   always_comb begin
      acc_next  = (acc_ff == CNT_MAX) ? acc_ff : acc_ff + CNT_W'(1);
      miss_next = (miss_ff == CNT_MAX) ? miss_ff : miss_ff + CNT_W'(1);

      priority if (hit_found_ff) begin
         wline = hit_line_ff;
      end else if (inv_found_ff) begin
         wline = inv_line_ff;
      end else begin
         wline = vic_line_ff;
      end

      acc_in       = acc_ff;
      miss_in      = miss_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_miss_in  = rsp_miss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.write) begin
         acc_in       = acc_next;
         miss_in      = hit_found_ff ? miss_ff : miss_next;
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_found_ff;
         rsp_acc_in   = acc_next;
         rsp_miss_in  = hit_found_ff ? miss_ff : miss_next;
      end

      clr_idx_in = clr_idx_ff;
      if (cmd.clear) begin
         clr_idx_in = clr_idx_ff + LINE_W'(1);
      end

      tag_we    = cmd.clear || cmd.write;
      tag_waddr = cmd.clear ? clr_idx_ff : wline;
      tag_wdata = cmd.clear ? '0 : {1'b1, tag_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mcnt_ff      <= '0;
         iss_k_ff     <= '0;
         rv_ff        <= 1'b0;
         hit_found_ff <= 1'b0;
         inv_found_ff <= 1'b0;
         vic_any_ff   <= 1'b0;
         clr_idx_ff   <= '0;
         acc_ff       <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mcnt_ff      <= mcnt_in;
         iss_k_ff     <= iss_k_in;
         rv_ff        <= rv_in;
         hit_found_ff <= hit_found_in;
         inv_found_ff <= inv_found_in;
         vic_any_ff   <= vic_any_in;
         clr_idx_ff   <= clr_idx_in;
         acc_ff       <= acc_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff       <= tag_in;
      base_ff      <= base_in;
      ways_ff      <= ways_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      iss_line_ff  <= iss_line_in;
      rv_line_ff   <= rv_line_in;
      hit_line_ff  <= hit_line_in;
      inv_line_ff  <= inv_line_in;
      vic_line_ff  <= vic_line_in;
      vic_stamp_ff <= vic_stamp_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_miss_ff  <= rsp_miss_in;
   end

   sacl_ram #(
      .WIDTH (TAG_DW),
      .DEPTH (LINES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (tag_waddr),
      .wr_data (tag_wdata),
      .rd_addr (iss_line_ff),
      .rd_data (tag_rdata)
   );

   sacl_ram #(
      .WIDTH (CNT_W),
      .DEPTH (LINES)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (wline),
      .wr_data (acc_next),
      .rd_addr (iss_line_ff),
      .rd_data (stamp_rdata)
   );

   always_comb begin
      st.clear_last = (clr_idx_ff == LINE_W'(LINES - 1));
      st.mod_done   = POW2 || (mcnt_ff == '0);
      st.scan_done  = (iss_k_ff == ways_ff);
      st.out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_miss_ff, rsp_acc_ff};
   assign rsp_tuser  = rsp_hit_ff;

endmodule

### hdl/set_assoc_cache_lru_tracker_top.sv
// Set-associative tag store with LRU replacement: register file, controller and datapath.
// Flow: an accepted request goes through line index reduction (only when LINES is not a power
//   of two), a scan of the W = min(2^way_bits, MAX_WAYS) ways of the set and write-back, which
//   waits while the result register still holds an untaken result. No new request is taken before
//   the write-back; the set is read one way per cycle through the single read port of the tag and stamp RAMs.
// Reset: counters zero, registers at their reset values, then a clearing pass invalidates every line;
//   no request is taken during it, register writes are.
module set_assoc_cache_lru_tracker_top
   import sacl_pkg::*;
#(
   parameter int LINES     = 256,
   parameter int MAX_WAYS  = 8,
   parameter int ADDR_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // [31:0] address
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [63:0]       rsp_tdata,   // [31:0] access_number, [63:32] miss_total
   output logic              rsp_tuser,   // [0] hit
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [OFS_W-1:0]  ofs_ff, ofs_in;
   logic [SETB_W-1:0] setb_ff, setb_in;
   logic [WAYB_W-1:0] wayb_ff, wayb_in;
   logic              csr_wr;
   logic [1:0]        csr_idx;

   sacl_cmd_type cmd;
   sacl_sts_type st;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      ofs_in  = ofs_ff;
      setb_in = setb_ff;
      wayb_in = wayb_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_OFFSET_BITS: ofs_in  = csr_pwdata[OFS_W-1:0];
            REG_SET_BITS:    setb_in = csr_pwdata[SETB_W-1:0];
            REG_WAY_BITS:    wayb_in = csr_pwdata[WAYB_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_OFFSET_BITS: csr_prdata = CSR_DW'(ofs_ff);
         REG_SET_BITS:    csr_prdata = CSR_DW'(setb_ff);
         REG_WAY_BITS:    csr_prdata = CSR_DW'(wayb_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ofs_ff  <= OFS_RST;
         setb_ff <= SETB_RST;
         wayb_ff <= WAYB_RST;
      end else begin
         ofs_ff  <= ofs_in;
         setb_ff <= setb_in;
         wayb_ff <= wayb_in;
      end
   end

   sacl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   sacl_dp #(
      .LINES     (LINES),
      .MAX_WAYS  (MAX_WAYS),
      .ADDR_BITS (ADDR_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg_ofs    (ofs_ff),
      .cfg_setb   (setb_ff),
      .cfg_wayb   (wayb_ff),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .st         (st),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_miss_le_access: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[63:32] <= rsp_tdata[31:0]))
      else $error("miss total exceeds access number");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous one in flight");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten before taken");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> (!req_tready && !rsp_tvalid && !cmd.write))
      else $error("activity during clearing pass");

endmodule
